// ===== design/nectx_pkg.sv =====
// nectx_pkg: shared types and constants of the NEC IR frame transmitter
// used by the channel interfaces and by nec_ir_frame_transmitter
// no dependencies
package nectx_pkg;

    // number of code bits sent in one frame
    localparam int CODE_BITS   = 32;
    localparam int BITS_LEFT_W = $clog2(CODE_BITS + 1);

    // input and configuration field widths
    localparam int CODE_W      = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_VALUE_W = 16;

    // input commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_HALF = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEADER_MARK  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEADER_SPACE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_MARK     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_SPACE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_SPACE    = 3'd5;

    // configuration reset values
    localparam logic [7:0]  RST_CARRIER_HALF = 8'd13;
    localparam logic [9:0]  RST_LEADER_MARK  = 10'd346;
    localparam logic [15:0] RST_LEADER_SPACE = 16'd4500;
    localparam logic [9:0]  RST_BIT_MARK     = 10'd21;
    localparam logic [15:0] RST_ZERO_SPACE   = 16'd562;
    localparam logic [15:0] RST_ONE_SPACE    = 16'd1686;

    // one input item
    typedef struct packed {
        logic              command;
        logic [CODE_W-1:0] code;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic frame_done;
        logic start_refused;
    } out_item_t;

    // one configuration write
    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_VALUE_W-1:0] value;
    } cfg_item_t;

endpackage

// ===== design/nectx_in_if.sv =====
// nectx_in_if: valid/ready channel carrying input items
// depends on nectx_pkg
interface nectx_in_if;
    logic                valid;
    logic                ready;
    nectx_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/nectx_out_if.sv =====
// nectx_out_if: valid/ready channel carrying result items
// depends on nectx_pkg
interface nectx_out_if;
    logic                 valid;
    logic                 ready;
    nectx_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/nectx_cfg_if.sv =====
// nectx_cfg_if: valid/ready channel carrying configuration writes
// depends on nectx_pkg
interface nectx_cfg_if;
    logic                 valid;
    logic                 ready;
    nectx_pkg::cfg_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/nec_ir_frame_transmitter.sv =====
// nec_ir_frame_transmitter: NEC infrared frame sequencer, one tick or start per item
// depends on nectx_pkg, nectx_in_if, nectx_out_if, nectx_cfg_if
// path: an item is held in the input register, and its result is then held in the result
//   register, from which it is offered on the output channel
// throughput: one item per cycle while results are taken; a waiting result stalls the
//   input once the input register also holds an item
// reset: asynchronous, clears frame state and both stages, registers take their defaults
module nec_ir_frame_transmitter (
    input  logic               clk,
    input  logic               rst_n,
    nectx_in_if.sink           in_ch,
    nectx_out_if.source        out_ch,
    nectx_cfg_if.sink          cfg_ch
);
    import nectx_pkg::*;

    // phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LMARK  = 3'd1;
    localparam logic [2:0] PH_LSPACE = 3'd2;
    localparam logic [2:0] PH_BMARK  = 3'd3;
    localparam logic [2:0] PH_BSPACE = 3'd4;
    localparam logic [2:0] PH_SMARK  = 3'd5;

    // configuration registers
    logic [7:0]  carrier_half_reg;
    logic [9:0]  leader_mark_reg;
    logic [15:0] leader_space_reg;
    logic [9:0]  bit_mark_reg;
    logic [15:0] zero_space_reg;
    logic [15:0] one_space_reg;

    // pipeline stages
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      advance;

    // frame state
    logic [2:0]             phase_reg, phase_next;
    logic [CODE_BITS-1:0]   shift_reg, shift_next;
    logic [BITS_LEFT_W-1:0] bits_left_reg, bits_left_next;
    logic [7:0]             half_count_reg, half_count_next;
    logic [9:0]             cycle_count_reg, cycle_count_next;
    logic [15:0]            space_count_reg, space_count_next;
    logic                   level_reg, level_next;

    // shared counter arithmetic
    logic [9:0]             burst_len;
    logic [15:0]            space_len;
    logic [7:0]             half_inc;
    logic [10:0]            cycle_inc;
    logic [16:0]            space_inc;
    logic                   half_wrap;
    logic                   cycle_last;
    logic                   burst_end;
    logic                   space_end;
    logic [BITS_LEFT_W-1:0] bits_dec;
    logic                   done;
    logic                   refused;

    // configuration writes, always accepted
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_half_reg <= RST_CARRIER_HALF;
            leader_mark_reg  <= RST_LEADER_MARK;
            leader_space_reg <= RST_LEADER_SPACE;
            bit_mark_reg     <= RST_BIT_MARK;
            zero_space_reg   <= RST_ZERO_SPACE;
            one_space_reg    <= RST_ONE_SPACE;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.data.index)
                CFG_CARRIER_HALF: carrier_half_reg <= cfg_ch.data.value[7:0];
                CFG_LEADER_MARK:  leader_mark_reg  <= cfg_ch.data.value[9:0];
                CFG_LEADER_SPACE: leader_space_reg <= cfg_ch.data.value;
                CFG_BIT_MARK:     bit_mark_reg     <= cfg_ch.data.value[9:0];
                CFG_ZERO_SPACE:   zero_space_reg   <= cfg_ch.data.value;
                CFG_ONE_SPACE:    one_space_reg    <= cfg_ch.data.value;
                default:          ;
            endcase
        end
    end

    // handshake between the stages
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg <= in_ch.data;
        end
    end

    // counter arithmetic shared by all burst and space phases
    assign burst_len  = (phase_reg == PH_LMARK) ? leader_mark_reg : bit_mark_reg;
    assign space_len  = (phase_reg == PH_LSPACE) ? leader_space_reg :
                        (shift_reg[CODE_BITS-1] ? one_space_reg : zero_space_reg);
    assign half_inc   = half_count_reg + 8'd1;
    assign cycle_inc  = {1'b0, cycle_count_reg} + 11'd1;
    assign space_inc  = {1'b0, space_count_reg} + 17'd1;
    assign half_wrap  = !(half_inc < carrier_half_reg);
    assign cycle_last = cycle_inc >= {1'b0, burst_len};
    assign burst_end  = half_wrap && !level_reg && cycle_last;
    assign space_end  = space_inc >= {1'b0, space_len};
    assign bits_dec   = (bits_left_reg != '0) ? bits_left_reg - BITS_LEFT_W'(1)
                                               : bits_left_reg;

    // next frame state for the item in the input register
    always_comb
    begin
        phase_next       = phase_reg;
        shift_next       = shift_reg;
        bits_left_next   = bits_left_reg;
        half_count_next  = half_count_reg;
        cycle_count_next = cycle_count_reg;
        space_count_next = space_count_reg;
        level_next       = level_reg;
        done             = 1'b0;
        refused          = 1'b0;

        if (in_item_reg.command == CMD_START)
        begin
            if (phase_reg != PH_IDLE)
            begin
                refused = 1'b1;
            end
            else
            begin
                shift_next       = CODE_BITS'(in_item_reg.code);
                bits_left_next   = BITS_LEFT_W'(CODE_BITS);
                phase_next       = PH_LMARK;
                half_count_next  = '0;
                cycle_count_next = '0;
                level_next       = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg) inside
                PH_IDLE:
                begin
                end
                PH_LMARK, PH_BMARK, PH_SMARK:
                begin
                    // carrier burst: half periods, then whole cycles
                    if (!half_wrap)
                    begin
                        half_count_next = half_inc;
                    end
                    else
                    begin
                        half_count_next = '0;
                        if (level_reg)
                        begin
                            level_next = 1'b0;
                        end
                        else if (cycle_last)
                        begin
                            cycle_count_next = '0;
                        end
                        else
                        begin
                            cycle_count_next = cycle_inc[9:0];
                            level_next       = 1'b1;
                        end
                    end
                    if (burst_end)
                    begin
                        if (phase_reg == PH_SMARK)
                        begin
                            phase_next = PH_IDLE;
                            level_next = 1'b0;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next       = (phase_reg == PH_LMARK) ? PH_LSPACE
                                                                       : PH_BSPACE;
                            space_count_next = '0;
                            level_next       = 1'b0;
                        end
                    end
                end
                PH_LSPACE, PH_BSPACE:
                begin
                    // silent space, then the next burst
                    if (space_end)
                    begin
                        space_count_next = '0;
                        half_count_next  = '0;
                        cycle_count_next = '0;
                        level_next       = 1'b1;
                        if (phase_reg == PH_LSPACE)
                        begin
                            phase_next = PH_BMARK;
                        end
                        else
                        begin
                            shift_next     = {shift_reg[CODE_BITS-2:0], 1'b0};
                            bits_left_next = bits_dec;
                            phase_next     = (bits_dec == '0) ? PH_SMARK : PH_BMARK;
                        end
                    end
                    else
                    begin
                        space_count_next = space_inc[15:0];
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    level_next = 1'b0;
                end
            endcase
        end

        out_item_next.led_on        = level_next;
        out_item_next.busy_res      = (phase_next != PH_IDLE);
        out_item_next.frame_done    = done;
        out_item_next.start_refused = refused;
    end

    // frame state update, one item per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            shift_reg       <= '0;
            bits_left_reg   <= '0;
            half_count_reg  <= '0;
            cycle_count_reg <= '0;
            space_count_reg <= '0;
            level_reg       <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            shift_reg       <= shift_next;
            bits_left_reg   <= bits_left_next;
            half_count_reg  <= half_count_next;
            cycle_count_reg <= cycle_count_next;
            space_count_reg <= space_count_next;
            level_reg       <= level_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_item_reg;

    // a finished frame is never reported busy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.frame_done |-> !out_item_reg.busy_res)
        else $error("frame_done with busy_res set");

    // a refused start only happens while a frame is running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.start_refused |-> out_item_reg.busy_res)
        else $error("start_refused while idle");

    // led only lights inside a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg |-> (phase_reg != PH_IDLE))
        else $error("carrier level high while idle");

    // a stalled item stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled input item lost");

    // bit counter never exceeds the code length
    assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= BITS_LEFT_W'(CODE_BITS))
        else $error("bits_left out of range");

endmodule
